@@ rtl/core/atn_pkg.sv @@
// Shared types and codes for the adaptive trace neuron step unit.
package atn_pkg;

  typedef struct packed {
    logic [1:0]         action;
    logic               spike_in;
    logic signed [31:0] pre_trace;
    logic signed [31:0] synapse_amp;
    logic               last_term;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] membrane_potential;
    logic signed [31:0] trace_out;
    logic               spike_out;
    logic               potential_final;
  } out_item_t;

  localparam logic [1:0] ACT_SPIKE = 2'd0;
  localparam logic [1:0] ACT_EULER = 2'd1;
  localparam logic [1:0] ACT_PRE   = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic [1:0] REG_DT     = 2'd0;
  localparam logic [1:0] REG_DECAY  = 2'd1;
  localparam logic [1:0] REG_GAIN   = 2'd2;
  localparam logic [1:0] REG_UNUSED = 2'd3;

endpackage

@@ rtl/core/atn_chan_if.sv @@
// Valid/ready stream channel carrying one request payload of type T.
interface atn_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/atn_exp_lut.sv @@
// Registered exp(-bias) lookup: bias clamp, table index and constant table.
module atn_exp_lut #(
  parameter int EXP_TABLE_ENTRIES = 256,
  parameter int FRAC_BITS         = 16
) (
  input  logic               clk,
  input  logic signed [31:0] bias_i,
  output logic [31:0]        exp_o
);

  localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES);
  localparam int NUM_W = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int OFF_W = FRAC_BITS + 4;
  localparam int PRD_W = OFF_W + NUM_W;
  localparam logic signed [31:0] BIAS_LO = -(32'sd1 <<< (FRAC_BITS + 3));
  localparam logic signed [31:0] BIAS_HI = (32'sd1 <<< (FRAC_BITS + 3)) - 32'sd1;
  localparam longint ONE24 = longint'(1) << 24;
  localparam int SHR = 24 - FRAC_BITS;
  localparam longint unsigned RND = (SHR > 0) ? (64'd1 << (SHR - 1)) : 64'd0;

  logic [31:0]      exp_tab [EXP_TABLE_ENTRIES];
  logic signed [31:0] bias_clamped;
  logic [31:0]      off_full;
  logic [PRD_W-1:0] idx_prod;
  logic [IDX_W-1:0] idx_r;
  logic [31:0]      exp_r;

  // Each entry is exp(8 - 16k/N): e^(x/64) by a Taylor sum, then squared six times.
  for (genvar k = 0; k < EXP_TABLE_ENTRIES; k++) begin : g_tab
    localparam longint Y = ((longint'(8) * EXP_TABLE_ENTRIES - longint'(16) * k)
                            * (longint'(1) << 18)) / EXP_TABLE_ENTRIES;
    localparam longint T1  = (ONE24 * Y) / ONE24 / 1;
    localparam longint T2  = (T1 * Y) / ONE24 / 2;
    localparam longint T3  = (T2 * Y) / ONE24 / 3;
    localparam longint T4  = (T3 * Y) / ONE24 / 4;
    localparam longint T5  = (T4 * Y) / ONE24 / 5;
    localparam longint T6  = (T5 * Y) / ONE24 / 6;
    localparam longint T7  = (T6 * Y) / ONE24 / 7;
    localparam longint T8  = (T7 * Y) / ONE24 / 8;
    localparam longint T9  = (T8 * Y) / ONE24 / 9;
    localparam longint T10 = (T9 * Y) / ONE24 / 10;
    localparam longint T11 = (T10 * Y) / ONE24 / 11;
    localparam longint T12 = (T11 * Y) / ONE24 / 12;
    localparam longint SUM = ONE24 + T1 + T2 + T3 + T4 + T5 + T6 + T7 + T8 + T9
                             + T10 + T11 + T12;
    localparam longint unsigned V0 = longint'(SUM);
    localparam longint unsigned V1 = (V0 * V0) >> 24;
    localparam longint unsigned V2 = (V1 * V1) >> 24;
    localparam longint unsigned V3 = (V2 * V2) >> 24;
    localparam longint unsigned V4 = (V3 * V3) >> 24;
    localparam longint unsigned V5 = (V4 * V4) >> 24;
    localparam longint unsigned V6 = (V5 * V5) >> 24;
    localparam longint unsigned VR = (V6 + RND) >> SHR;
    localparam logic [31:0] ENTRY = (VR > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(VR);
    assign exp_tab[k] = ENTRY;
  end

  always_comb begin
    if (bias_i < BIAS_LO) begin
      bias_clamped = BIAS_LO;
    end else if (bias_i > BIAS_HI) begin
      bias_clamped = BIAS_HI;
    end else begin
      bias_clamped = bias_i;
    end
    off_full = 32'(bias_clamped - BIAS_LO);
    idx_prod = PRD_W'(off_full[OFF_W-1:0]) * PRD_W'(EXP_TABLE_ENTRIES);
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_prod[OFF_W +: IDX_W];
    exp_r <= exp_tab[idx_r];
  end

  assign exp_o = exp_r;

endmodule

@@ rtl/core/adaptive_trace_neuron_step_unit.sv @@
// Top level: neuron state, APB registers, sequencer and one shared 33x33 multiplier.
// Set spike and clear pass through their own state, a presynaptic term through multiply
// and accumulate, an Euler step through trace multiply, gain multiply, g subtract, dt
// multiply and bias update, each then waiting in push for a free output slot. The sequencer takes
// a new request only from idle, while an earlier result may still wait in the output register.
// Synchronous active-low reset clears the neuron state and loads register defaults.
module adaptive_trace_neuron_step_unit #(
  parameter int EXP_TABLE_ENTRIES = 256,
  parameter int FRAC_BITS         = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  atn_chan_if.sink    in_ch,
  atn_chan_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SPIKE  = 4'd1;
  localparam logic [3:0] ST_CLEAR  = 4'd2;
  localparam logic [3:0] ST_PMUL   = 4'd3;
  localparam logic [3:0] ST_PACC   = 4'd4;
  localparam logic [3:0] ST_TMUL   = 4'd5;
  localparam logic [3:0] ST_GMUL   = 4'd6;
  localparam logic [3:0] ST_GSUB   = 4'd7;
  localparam logic [3:0] ST_DMUL   = 4'd8;
  localparam logic [3:0] ST_BIAS   = 4'd9;
  localparam logic [3:0] ST_PUSH   = 4'd10;

  localparam logic [30:0] DT_RST    = 31'd66;
  localparam logic [30:0] DECAY_RST = 31'd3277;
  localparam logic [30:0] GAIN_RST  = 31'd486320;

  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'(v);
    end
    return res;
  endfunction

  logic [3:0]  state_r, state_nxt;
  logic        spike_r, spike_nxt;
  logic signed [31:0] trace_r, trace_nxt;
  logic signed [31:0] bias_r, bias_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic [30:0] dt_r, decay_r, gain_r;
  logic        out_valid_r, out_valid_nxt;

  atn_pkg::in_item_t  item_r;
  atn_pkg::out_item_t out_item_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] g_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  logic signed [63:0] q_prod;
  logic        q_fix;
  logic [31:0] exp_val;
  logic        in_take;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  logic        slot_free;

  atn_exp_lut #(
    .EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES),
    .FRAC_BITS(FRAC_BITS)
  ) u_exp (
    .clk(clk),
    .bias_i(bias_r),
    .exp_o(exp_val)
  );

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_idx)
      atn_pkg::REG_DT:    cfg_prdata = {1'b0, dt_r};
      atn_pkg::REG_DECAY: cfg_prdata = {1'b0, decay_r};
      atn_pkg::REG_GAIN:  cfg_prdata = {1'b0, gain_r};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r    <= DT_RST;
      decay_r <= DECAY_RST;
      gain_r  <= GAIN_RST;
    end else if (cfg_wr) begin
      if (cfg_idx == atn_pkg::REG_DT) begin
        dt_r <= cfg_pwdata[30:0];
      end
      if (cfg_idx == atn_pkg::REG_DECAY) begin
        decay_r <= cfg_pwdata[30:0];
      end
      if (cfg_idx == atn_pkg::REG_GAIN) begin
        gain_r <= cfg_pwdata[30:0];
      end
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  // Shared multiplier operand selection.
  always_comb begin
    unique case (state_r)
      ST_TMUL: begin
        mul_a = $signed({2'b00, decay_r});
        mul_b = $signed({trace_r[31], trace_r});
      end
      ST_GMUL: begin
        mul_a = $signed({2'b00, gain_r});
        mul_b = $signed({exp_val[31], exp_val});
      end
      ST_DMUL: begin
        mul_a = $signed({g_r[31], g_r});
        mul_b = $signed({2'b00, dt_r});
      end
      ST_PMUL: begin
        mul_a = $signed({item_r.pre_trace[31], item_r.pre_trace});
        mul_b = $signed({item_r.synapse_amp[31], item_r.synapse_amp});
      end
      default: begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Fixed-point product scaled down with truncation toward zero.
  assign q_fix  = prod_r[63] && (prod_r[FRAC_BITS-1:0] != '0);
  assign q_prod = (prod_r >>> FRAC_BITS) + $signed({63'd0, q_fix});

  always_comb begin
    state_nxt     = state_r;
    spike_nxt     = spike_r;
    trace_nxt     = trace_r;
    bias_nxt      = bias_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          unique case (in_ch.data.action)
            atn_pkg::ACT_SPIKE: state_nxt = ST_SPIKE;
            atn_pkg::ACT_EULER: state_nxt = ST_TMUL;
            atn_pkg::ACT_PRE:   state_nxt = ST_PMUL;
            default:            state_nxt = ST_CLEAR;
          endcase
        end
      end
      ST_SPIKE: begin
        spike_nxt = item_r.spike_in;
        if (item_r.spike_in) begin
          trace_nxt = sat32(64'(trace_r) + ONE);
        end
        state_nxt = ST_PUSH;
      end
      ST_CLEAR: begin
        spike_nxt = 1'b0;
        trace_nxt = 32'sd0;
        bias_nxt  = 32'sd0;
        acc_nxt   = 32'sd0;
        state_nxt = ST_PUSH;
      end
      ST_PMUL: state_nxt = ST_PACC;
      ST_PACC: begin
        acc_nxt   = sat32(64'(acc_r) + q_prod);
        state_nxt = ST_PUSH;
      end
      ST_TMUL: state_nxt = ST_GMUL;
      ST_GMUL: begin
        // Trace decay lands while the multiplier forms gain times exp.
        trace_nxt = sat32(64'(trace_r) - q_prod);
        state_nxt = ST_GSUB;
      end
      ST_GSUB: state_nxt = ST_DMUL;
      ST_DMUL: state_nxt = ST_BIAS;
      ST_BIAS: begin
        bias_nxt  = sat32(64'(bias_r) + q_prod);
        acc_nxt   = sat32(64'(bias_r) + q_prod);
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      spike_r     <= 1'b0;
      trace_r     <= 32'sd0;
      bias_r      <= 32'sd0;
      acc_r       <= 32'sd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      spike_r     <= spike_nxt;
      trace_r     <= trace_nxt;
      bias_r      <= bias_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(mul_full[63:0]);
    if (in_take) begin
      item_r <= in_ch.data;
    end
    if (state_r == ST_GSUB) begin
      // Without a spike the exp term drops out and g is just -1.0.
      g_r <= sat32((spike_r ? q_prod : 64'sd0) - ONE);
    end
    if (state_r == ST_PUSH && slot_free) begin
      out_item_r.membrane_potential <= acc_r;
      out_item_r.trace_out          <= trace_r;
      out_item_r.spike_out          <= spike_r;
      out_item_r.potential_final    <= (item_r.action == atn_pkg::ACT_PRE) &&
                                       item_r.last_term;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

endmodule

@@ rtl/core/atn_check.sv @@
// Port-level checker for the neuron step unit, bound to the top level.
module atn_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        in_spike,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_acc,
  input logic [31:0] out_trace,
  input logic        out_spike,
  input logic        out_final
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A result waiting on the output holds still until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_acc) && $stable(out_trace) &&
      $stable(out_spike) && $stable(out_final))
    else $error("output result changed while stalled");

  // Requests are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request accepted while busy");

  // A clear request with an empty output slot yields an all-zero result.
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_action == atn_pkg::ACT_CLEAR && !out_valid |=> ##2
      out_valid && out_acc == 32'd0 && out_trace == 32'd0 && !out_spike && !out_final)
    else $error("clear request did not give a zeroed result");

  // A set-spike request reports the new flag and no final-sum mark.
  a_spike_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_action == atn_pkg::ACT_SPIKE && !out_valid |=> ##2
      out_valid && !out_final && out_spike == $past(in_spike, 3))
    else $error("set-spike request gave a wrong flag");

endmodule

bind adaptive_trace_neuron_step_unit atn_check u_atn_check (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .in_action(in_ch.data.action),
  .in_spike(in_ch.data.spike_in),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_acc(out_ch.data.membrane_potential),
  .out_trace(out_ch.data.trace_out),
  .out_spike(out_ch.data.spike_out),
  .out_final(out_ch.data.potential_final)
);
